// ===== hw/rtl/okvt_pkg.sv =====
// ----------------------------------------------------------------------------
// okvt_pkg
// shared constants for the insertion-ordered key-value table
// ----------------------------------------------------------------------------
package okvt_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = KEY_BITS + VALUE_BITS;

    // request fields
    localparam int OP_W   = 2;
    localparam int FKEY_W = 32;
    localparam int FVAL_W = 32;
    localparam int POS_W  = 4;
    localparam int FCNT_W = 5;

    localparam int OP_LSB  = 0;
    localparam int KEY_LSB = OP_LSB + OP_W;
    localparam int VAL_LSB = KEY_LSB + FKEY_W;
    localparam int POS_LSB = VAL_LSB + FVAL_W;
    localparam int INS_BIT = POS_LSB + POS_W;
    localparam int UPD_BIT = INS_BIT + 1;

    localparam int IN_FIELDS_W  = UPD_BIT + 1;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + FKEY_W + FVAL_W + FCNT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CMP_W = POS_W + CNT_W;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_FIND_KEY = 2'd0;
    localparam t_op OP_FIND_POS = 2'd1;
    localparam t_op OP_WRITE    = 2'd2;
    localparam t_op OP_ERASE    = 2'd3;

endpackage

// ===== hw/rtl/okvt_ram.sv =====
// ----------------------------------------------------------------------------
// okvt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module okvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== hw/rtl/ordered_key_value_table_core.sv =====
// ----------------------------------------------------------------------------
// ordered_key_value_table_core
// insertion-ordered key-value table held in one ram, searched one entry per cycle
//
// channel  dir  fields (lsb first)
// s_axis   in   operation, lookup_key, write_value, position, may_insert, may_update
// m_axis   out  success, found_key, found_value, entry_count, table_full
//
// one request at a time; a key search streams through the ram at one entry
// per cycle; an erase then moves each later entry down one place
// a position lookup reads the ram in S_POS and takes the entry in S_POSRD,
// or goes straight to S_DONE when the position is past the count
// reset clears the entry count and the output valid flag; ram contents are
// only read below the count
// a stalled result waits in the output register while the next request runs
// ----------------------------------------------------------------------------
module ordered_key_value_table_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // operation, lookup_key, write_value, position, may_insert, may_update
    input  logic [okvt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // success, found_key, found_value, entry_count, table_full, zero pad
    output logic [okvt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import okvt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_POS    = 3'd1;
    localparam logic [2:0] S_POSRD  = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]            r_state,    n_state;
    logic [CNT_W-1:0]      r_count,    n_count;
    logic [CNT_W-1:0]      r_ptr,      n_ptr;
    logic                  r_pend,     n_pend;
    logic [IDX_W-1:0]      r_pend_idx, n_pend_idx;
    t_op                   r_op,       n_op;
    logic [KEY_BITS-1:0]   r_key,      n_key;
    logic [VALUE_BITS-1:0] r_val,      n_val;
    logic [POS_W-1:0]      r_pos,      n_pos;
    logic                  r_ins,      n_ins;
    logic                  r_upd,      n_upd;

    logic                  r_res_success, n_res_success;
    logic [FKEY_W-1:0]     r_res_key,     n_res_key;
    logic [FVAL_W-1:0]     r_res_value,   n_res_value;
    logic                  r_res_full,    n_res_full;

    logic                  r_out_valid,   n_out_valid;
    logic                  r_out_success, n_out_success;
    logic [FKEY_W-1:0]     r_out_key,     n_out_key;
    logic [FVAL_W-1:0]     r_out_value,   n_out_value;
    logic [FCNT_W-1:0]     r_out_count,   n_out_count;
    logic                  r_out_full,    n_out_full;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic                  hit;
    logic                  pos_ok;
    logic                  s_fire;

    okvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[ENTRY_W-1:VALUE_BITS];
    assign rd_value = ram_rdata[VALUE_BITS-1:0];
    assign hit      = r_pend && (rd_key == r_key);
    assign pos_ok   = CMP_W'(r_pos) < CMP_W'(r_count);

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_full, r_out_count, r_out_value,
                                         r_out_key, r_out_success});

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_ptr         = r_ptr;
        n_pend        = r_pend;
        n_pend_idx    = r_pend_idx;
        n_op          = r_op;
        n_key         = r_key;
        n_val         = r_val;
        n_pos         = r_pos;
        n_ins         = r_ins;
        n_upd         = r_upd;
        n_res_success = r_res_success;
        n_res_key     = r_res_key;
        n_res_value   = r_res_value;
        n_res_full    = r_res_full;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_success = r_out_success;
        n_out_key     = r_out_key;
        n_out_value   = r_out_value;
        n_out_count   = r_out_count;
        n_out_full    = r_out_full;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_op          = s_axis_tdata[OP_LSB +: OP_W];
                    n_key         = KEY_BITS'(s_axis_tdata[KEY_LSB +: FKEY_W]);
                    n_val         = VALUE_BITS'(s_axis_tdata[VAL_LSB +: FVAL_W]);
                    n_pos         = s_axis_tdata[POS_LSB +: POS_W];
                    n_ins         = s_axis_tdata[INS_BIT];
                    n_upd         = s_axis_tdata[UPD_BIT];
                    n_ptr         = '0;
                    n_pend        = 1'b0;
                    n_res_success = 1'b0;
                    n_res_key     = '0;
                    n_res_value   = '0;
                    n_res_full    = 1'b0;
                    n_state       = (s_axis_tdata[OP_LSB +: OP_W] == OP_FIND_POS)
                                    ? S_POS : S_SEARCH;
                end
            end
            S_POS: begin
                if (pos_ok) begin
                    ram_raddr = IDX_W'(r_pos);
                    n_state   = S_POSRD;
                end else begin
                    n_state   = S_DONE;
                end
            end
            S_POSRD: begin
                n_res_success = 1'b1;
                n_res_key     = FKEY_W'(rd_key);
                n_res_value   = FVAL_W'(rd_value);
                n_state       = S_DONE;
            end
            S_SEARCH: begin
                if (hit) begin
                    n_state = S_DONE;
                    case (r_op)
                        OP_FIND_KEY: begin
                            n_res_success = 1'b1;
                            n_res_value   = FVAL_W'(rd_value);
                        end
                        OP_WRITE: begin
                            if (r_upd) begin
                                ram_we        = 1'b1;
                                ram_waddr     = r_pend_idx;
                                ram_wdata     = {r_key, r_val};
                                n_res_success = 1'b1;
                            end
                        end
                        OP_ERASE: begin
                            n_ptr   = CNT_W'(r_pend_idx) + CNT_W'(1);
                            n_pend  = 1'b0;
                            n_state = S_SHIFT;
                        end
                        default: begin
                        end
                    endcase
                end else if (r_ptr == r_count) begin
                    n_state = S_DONE;
                    if (r_op == OP_WRITE && r_ins) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_res_full = 1'b1;
                        end else begin
                            ram_we        = 1'b1;
                            ram_waddr     = r_count[IDX_W-1:0];
                            ram_wdata     = {r_key, r_val};
                            n_count       = r_count + CNT_W'(1);
                            n_res_success = 1'b1;
                        end
                    end
                end else begin
                    ram_raddr  = r_ptr[IDX_W-1:0];
                    n_ptr      = r_ptr + CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_ptr[IDX_W-1:0];
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_idx - IDX_W'(1);
                    ram_wdata = ram_rdata;
                end
                if (r_ptr == r_count) begin
                    n_count       = r_count - CNT_W'(1);
                    n_res_success = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    ram_raddr  = r_ptr[IDX_W-1:0];
                    n_ptr      = r_ptr + CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_ptr[IDX_W-1:0];
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_success = r_res_success;
                    n_out_key     = r_res_key;
                    n_out_value   = r_res_value;
                    n_out_count   = FCNT_W'(r_count);
                    n_out_full    = r_res_full;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr         <= n_ptr;
        r_pend        <= n_pend;
        r_pend_idx    <= n_pend_idx;
        r_op          <= n_op;
        r_key         <= n_key;
        r_val         <= n_val;
        r_pos         <= n_pos;
        r_ins         <= n_ins;
        r_upd         <= n_upd;
        r_res_success <= n_res_success;
        r_res_key     <= n_res_key;
        r_res_value   <= n_res_value;
        r_res_full    <= n_res_full;
        r_out_success <= n_out_success;
        r_out_key     <= n_out_key;
        r_out_value   <= n_out_value;
        r_out_count   <= n_out_count;
        r_out_full    <= n_out_full;
    end

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_full |->
            r_out_count == FCNT_W'(CAPACITY) && !r_out_success)
        else $error("full flag without a full table");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            r_count == $past(r_count) ||
            r_count == CNT_W'($past(r_count) + CNT_W'(1)) ||
            r_count == CNT_W'($past(r_count) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == S_SEARCH || r_state == S_SHIFT)
        else $error("ram write outside search or shift");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> !s_axis_tready)
        else $error("request taken while another is in flight");

endmodule
